FILE: hw/rtl/fidl_pkg.sv
// Shared widths, constants and codes for the fade-in delay line.
`timescale 1ns / 1ps
package fidl_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int DELAY_W    = 15;
  localparam int GAIN_W     = 15;
  localparam int CFG_W      = 13;
  localparam int PROD_W     = 32;
  localparam int PROD_SHIFT = 14;
  localparam int IN_DATA_W  = 32;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 15'b100000000000000;
  localparam logic [GAIN_W-1:0] GAIN_STEP  = 15'b000000010000000;

  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((1 << PROD_SHIFT) - 1);
  localparam logic signed [PROD_W-1:0] OUT_MAX    = 32'sd32767;
  localparam logic signed [PROD_W-1:0] OUT_MIN    = -32'sd32768;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

endpackage

FILE: hw/rtl/fidl_mod_unit.sv
// Restoring serial modulo unit: reduces the delay by the line length, one bit a cycle.
`timescale 1ns / 1ps
module fidl_mod_unit
  import fidl_pkg::*;
#(
  parameter int LEN_W = 13
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DELAY_W-1:0] dividend,
  input  logic [LEN_W-1:0]   divisor,
  output logic               done,
  output logic [LEN_W-1:0]   remainder
);

  localparam int CNT_W = $clog2(DELAY_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DELAY_W-1:0] dvd_r;
  logic [LEN_W-1:0]   rem_r;
  logic [LEN_W:0]     trial;
  logic [LEN_W:0]     rem_nxt;

  // One shared subtract-and-compare per cycle.
  always_comb begin
    trial = {rem_r, dvd_r[DELAY_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = trial - {1'b0, divisor};
    end else begin
      rem_nxt = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DELAY_W - 1);
        dvd_r  <= dividend;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt[LEN_W-1:0];
        dvd_r <= {dvd_r[DELAY_W-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

FILE: hw/rtl/fade_in_delay_line_unit.sv
// Top level of the fade-in delay line: sample memory, sequencer and gain scaling.
// A write request goes through the response state to its result; a read request goes through
// the 15-step serial modulo unit, then the index, memory read, multiply and scaling steps.
// One request is handled at a time: no new request is taken until the last result is
// registered, and a stalled output holds the block in its result state.
// Reset (rst_n low at a clock edge) clears line length, position, gain, wrap flag and the
// output valid; the sample memory is not cleared and holds undefined data until written.
`timescale 1ns / 1ps
module fade_in_delay_line_unit
  import fidl_pkg::*;
#(
  parameter int MAX_LENGTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration: line length
  input  logic                 cfg_wen,
  input  logic [CFG_W-1:0]     cfg_data,
  // Request channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // [15:0] sample, [30:16] delay, [31] zero
  input  logic                 in_tuser,   // [0] kind (0 write, 1 read)
  // Result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [SAMPLE_W-1:0]  out_tdata,  // [15:0] value
  output logic                 out_tuser   // [0] error
);

  localparam int ADDR_W = $clog2(MAX_LENGTH);
  localparam int LEN_W  = $clog2(MAX_LENGTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_MUL,
    S_SCALE,
    S_RESP
  } state_t;

  state_t                     state_r;
  logic [LEN_W-1:0]           len_r;
  logic [ADDR_W-1:0]          wp_r;
  logic [GAIN_W-1:0]          gain_r;
  logic                       wrapped_r;
  logic [ADDR_W-1:0]          rd_addr_r;
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       res_err_r;
  logic                       out_tvalid_r;
  logic [SAMPLE_W-1:0]        out_tdata_r;
  logic                       out_tuser_r;

  // The sample memory; entries are defined only once written.
  logic signed [SAMPLE_W-1:0] mem [MAX_LENGTH];

  logic                       in_acc;
  logic                       line_empty;
  logic                       mem_we;
  logic                       div_start;
  logic                       div_done;
  logic [LEN_W-1:0]           div_rem;
  logic [LEN_W-1:0]           cfg_len;
  logic [LEN_W-1:0]           wp_inc;
  logic [LEN_W:0]             idx_diff;
  logic [LEN_W:0]             idx_fix;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [DELAY_W-1:0]         in_delay;
  logic signed [SAMPLE_W-1:0] gain_s;
  logic signed [PROD_W-1:0]   prod_adj;
  logic signed [PROD_W-1:0]   prod_sh;
  logic [SAMPLE_W-1:0]        scaled;
  logic                       out_free;

  assign in_sample  = in_tdata[SAMPLE_W-1:0];
  assign in_delay   = in_tdata[SAMPLE_W +: DELAY_W];
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign line_empty = (len_r == '0);
  assign mem_we     = in_acc && (in_tuser == KIND_WRITE) && !line_empty;
  assign div_start  = in_acc && (in_tuser == KIND_READ) && !line_empty;
  assign out_free   = !out_tvalid_r || out_tready;

  // Lengths beyond the memory size are clipped to it.
  assign cfg_len = (32'(cfg_data) > 32'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : LEN_W'(cfg_data);

  // The write position stays below the line length, so a single compare handles the wrap.
  assign wp_inc = LEN_W'(wp_r) + LEN_W'(1);

  // Read index: write position minus the reduced delay, folded back into the line.
  always_comb begin
    idx_diff = (LEN_W + 1)'(wp_r) - (LEN_W + 1)'(div_rem);
    if (idx_diff[LEN_W]) begin
      idx_fix = idx_diff + (LEN_W + 1)'(len_r);
    end else begin
      idx_fix = idx_diff;
    end
  end

  // Scaling: Q14 product divided by 2^14 towards zero, then clipped to 16 bits.
  always_comb begin
    gain_s = {1'b0, gain_r};
    if (prod_r[PROD_W-1]) begin
      prod_adj = prod_r + ROUND_BIAS;
    end else begin
      prod_adj = prod_r;
    end
    prod_sh = prod_adj >>> PROD_SHIFT;
    if (prod_sh > OUT_MAX) begin
      scaled = SAMPLE_W'(OUT_MAX);
    end else if (prod_sh < OUT_MIN) begin
      scaled = SAMPLE_W'(OUT_MIN);
    end else begin
      scaled = SAMPLE_W'(prod_sh);
    end
  end

  fidl_mod_unit #(
    .LEN_W (LEN_W)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_delay),
    .divisor   (len_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= in_sample;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      len_r        <= '0;
      wp_r         <= '0;
      gain_r       <= '0;
      wrapped_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // In the two result states a taken result is replaced by the next one below.
      if (out_tvalid_r && out_tready && !(state_r inside {S_SCALE, S_RESP})) begin
        out_tvalid_r <= 1'b0;
      end
      // A new length restarts the line; it must arrive only while the block is idle (not enforced here).
      if (cfg_wen) begin
        len_r     <= cfg_len;
        wp_r      <= '0;
        gain_r    <= '0;
        wrapped_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (line_empty) begin
              res_err_r <= 1'b1;
              state_r   <= S_RESP;
            end else if (in_tuser == KIND_WRITE) begin
              // The fade-in only starts once the line has been filled once.
              if (wrapped_r && (gain_r < GAIN_UNITY)) begin
                gain_r <= gain_r + GAIN_STEP;
              end
              if (wp_inc == len_r) begin
                wrapped_r <= 1'b1;
                wp_r      <= '0;
              end else begin
                wp_r <= ADDR_W'(wp_inc);
              end
              res_err_r <= 1'b0;
              state_r   <= S_RESP;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            rd_addr_r <= ADDR_W'(idx_fix);
            state_r   <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= gain_s * rd_data_r;
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= scaled;
            out_tuser_r  <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= '0;
            out_tuser_r  <= res_err_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

FILE: hw/rtl/fidl_checker.sv
// Port-level checker for the fade-in delay line, bound to the top level.
`timescale 1ns / 1ps
module fidl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Only one request is in flight: ready drops right after an acceptance.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // An error result always carries a zero value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 16'd0)
    else $error("error result with non-zero value");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind fade_in_delay_line_unit fidl_checker u_fidl_checker (.*);
